>>> src/fourier_tensor_vector_multiply_defines.svh
// assertion macros for the fourier tensor-vector multiplier checker
// used by: ftvm_checker.sv; expects clk and rst_n in scope
`ifndef FOURIER_TENSOR_VECTOR_MULTIPLY_DEFINES_SVH
`define FOURIER_TENSOR_VECTOR_MULTIPLY_DEFINES_SVH

// same-cycle implication
`define FTVM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftvm checker: property failed");

// next-cycle implication
`define FTVM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftvm checker: property failed");

`endif

>>> src/ftvm_pkg.sv
// shared types and constants of the fourier tensor-vector multiplier
// no dependencies
`timescale 1ns / 1ps

package ftvm_pkg;

    localparam int AXIS_MAX    = 16;
    localparam int AXIS_W      = $clog2(AXIS_MAX);
    localparam int COMPONENTS  = 6;
    localparam int COMP_W      = 3;
    localparam int POS_W       = 4;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int VAL_W       = 32;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int ENTRY_W     = 2 * VAL_W;
    localparam int STORE_DEPTH = AXIS_MAX * AXIS_MAX * AXIS_MAX;
    localparam int ADDR_W      = 3 * AXIS_W;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_MULT = 1'b1
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDED_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDED_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDED_Z = 3'd5;

    localparam logic [CFG_W-1:0] QUAD_RESET   = 5'd9;
    localparam logic [CFG_W-1:0] PADDED_RESET = 5'd16;

    typedef struct packed
    {
        opcode_t                  opcode;
        logic [COMP_W-1:0]        component;
        logic [POS_W-1:0]         pos_x;
        logic [POS_W-1:0]         pos_y;
        logic [POS_W-1:0]         pos_z;
        logic signed [VAL_W-1:0]  val0_re;
        logic signed [VAL_W-1:0]  val0_im;
        logic signed [VAL_W-1:0]  val1_re;
        logic signed [VAL_W-1:0]  val1_im;
        logic signed [VAL_W-1:0]  val2_re;
        logic signed [VAL_W-1:0]  val2_im;
    } cmd_t;

    typedef struct packed
    {
        logic signed [VAL_W-1:0]  out0_re;
        logic signed [VAL_W-1:0]  out0_im;
        logic signed [VAL_W-1:0]  out1_re;
        logic signed [VAL_W-1:0]  out1_im;
        logic signed [VAL_W-1:0]  out2_re;
        logic signed [VAL_W-1:0]  out2_im;
        logic                     bad_index;
    } result_t;

    // classified request as it waits between front and back
    typedef struct packed
    {
        logic                    is_mult;
        logic                    wr_en;
        logic [COMP_W-1:0]       component;
        logic [AXIS_W-1:0]       ix;
        logic [AXIS_W-1:0]       iy;
        logic [AXIS_W-1:0]       iz;
        logic                    neg_xy;
        logic                    neg_xz;
        logic                    neg_yz;
        logic                    bad;
        logic signed [VAL_W-1:0] v0_re;
        logic signed [VAL_W-1:0] v0_im;
        logic signed [VAL_W-1:0] v1_re;
        logic signed [VAL_W-1:0] v1_im;
        logic signed [VAL_W-1:0] v2_re;
        logic signed [VAL_W-1:0] v2_im;
    } entry_t;

    // tensor component used by result row r and vector column c
    function automatic logic [COMP_W-1:0] tensor_sel(input int r, input int c);
        logic [COMP_W-1:0] sel;
        begin
            sel = '0;
            if (r == 0 && c == 0) sel = 3'd0;
            else if ((r == 0 && c == 1) || (r == 1 && c == 0)) sel = 3'd1;
            else if ((r == 0 && c == 2) || (r == 2 && c == 0)) sel = 3'd2;
            else if (r == 1 && c == 1) sel = 3'd3;
            else if ((r == 1 && c == 2) || (r == 2 && c == 1)) sel = 3'd4;
            else sel = 3'd5;
            return sel;
        end
    endfunction

endpackage

>>> src/ftvm_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ftvm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ftvm_front.sv
// front end: configuration registers, index folding and request classification
// depends on ftvm_pkg
`timescale 1ns / 1ps

module ftvm_front
    import ftvm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  cmd_t                 cmd,
    output entry_t               entry
);

    logic [CFG_W-1:0] quad_x_reg, quad_y_reg, quad_z_reg;
    logic [CFG_W-1:0] pad_x_reg, pad_y_reg, pad_z_reg;

    logic [CFG_W-1:0] fx, fy, fz;
    logic             nx, ny, nz, bx, by, bz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_x_reg <= QUAD_RESET;
            quad_y_reg <= QUAD_RESET;
            quad_z_reg <= QUAD_RESET;
            pad_x_reg  <= PADDED_RESET;
            pad_y_reg  <= PADDED_RESET;
            pad_z_reg  <= PADDED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUAD_X:   quad_x_reg <= cfg_data;
                CFG_QUAD_Y:   quad_y_reg <= cfg_data;
                CFG_QUAD_Z:   quad_z_reg <= cfg_data;
                CFG_PADDED_X: pad_x_reg  <= cfg_data;
                CFG_PADDED_Y: pad_y_reg  <= cfg_data;
                CFG_PADDED_Z: pad_z_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // fold a padded index into the quadrant; upper half mirrors with sign -1
    function automatic void fold(input logic [POS_W-1:0] pos, input logic [CFG_W-1:0] q,
                                 input logic [CFG_W-1:0] pad, output logic [CFG_W-1:0] idx,
                                 output logic neg, output logic bad);
        logic [CFG_W-1:0] p;
        begin
            p   = CFG_W'(pos);
            neg = (p >= q);
            idx = neg ? (pad - p) : p;
            bad = (p >= pad) || (int'(idx) >= AXIS_MAX);
        end
    endfunction

    always_comb
    begin
        fold(cmd.pos_x, quad_x_reg, pad_x_reg, fx, nx, bx);
        fold(cmd.pos_y, quad_y_reg, pad_y_reg, fy, ny, by);
        fold(cmd.pos_z, quad_z_reg, pad_z_reg, fz, nz, bz);

        entry.is_mult   = (cmd.opcode == OP_MULT);
        entry.wr_en     = (cmd.opcode == OP_LOAD) && (int'(cmd.component) < COMPONENTS)
                          && (int'(cmd.pos_x) < AXIS_MAX) && (int'(cmd.pos_y) < AXIS_MAX)
                          && (int'(cmd.pos_z) < AXIS_MAX);
        entry.component = cmd.component;
        entry.neg_xy    = nx ^ ny;
        entry.neg_xz    = nx ^ nz;
        entry.neg_yz    = ny ^ nz;
        entry.bad       = bx || by || bz;
        if (cmd.opcode == OP_MULT)
        begin
            entry.ix = AXIS_W'(fx);
            entry.iy = AXIS_W'(fy);
            entry.iz = AXIS_W'(fz);
        end
        else
        begin
            entry.ix = AXIS_W'(cmd.pos_x);
            entry.iy = AXIS_W'(cmd.pos_y);
            entry.iz = AXIS_W'(cmd.pos_z);
        end
        entry.v0_re = cmd.val0_re;
        entry.v0_im = cmd.val0_im;
        entry.v1_re = cmd.val1_re;
        entry.v1_im = cmd.val1_im;
        entry.v2_re = cmd.val2_re;
        entry.v2_im = cmd.val2_im;
    end

endmodule

>>> src/ftvm_queue.sv
// two-entry request queue between front and back
// depends on ftvm_pkg
`timescale 1ns / 1ps

module ftvm_queue
    import ftvm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output entry_t head,
    output logic   head_valid,
    output logic   full
);

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && head_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop && head_valid);
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);

endmodule

>>> src/ftvm_back.sv
// back end: tensor store, complex products, signed sums, rounding and saturation
// depends on ftvm_pkg, ftvm_ram
`timescale 1ns / 1ps

module ftvm_back
    import ftvm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  entry_t  head,
    input  logic    head_valid,
    output logic    pop,
    output logic    done,
    output result_t result
);

    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata [COMPONENTS];

    assign pop   = head_valid;
    assign addr  = {head.iz, head.iy, head.ix};
    assign wdata = {head.v0_im, head.v0_re};

    for (genvar g = 0; g < COMPONENTS; g++)
    begin : g_store
        ftvm_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_ram (
            .clk   (clk),
            .we    (head_valid && head.wr_en && (int'(head.component) == g)),
            .addr  (addr),
            .wdata (wdata),
            .rdata (rdata[g])
        );
    end

    // stage 1: store read in flight
    logic   s1_valid_reg;
    entry_t s1_reg;
    // stage 2: products
    logic   s2_valid_reg, s2_bad_reg;
    logic   s2_nxy_reg, s2_nxz_reg, s2_nyz_reg;
    logic signed [PROD_W-1:0] prod_reg [3][3][4];
    // stage 3: sums
    logic   s3_valid_reg, s3_bad_reg;
    logic signed [ACC_W-1:0] acc_re_reg [3];
    logic signed [ACC_W-1:0] acc_im_reg [3];
    // output
    logic    done_reg;
    result_t result_reg;

    logic signed [VAL_W-1:0] vr [3];
    logic signed [VAL_W-1:0] vi [3];
    logic signed [PROD_W-1:0] prod_next [3][3][4];
    logic signed [ACC_W-1:0]  acc_re_next [3];
    logic signed [ACC_W-1:0]  acc_im_next [3];
    logic signed [VAL_W-1:0]  sat_re [3];
    logic signed [VAL_W-1:0]  sat_im [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= head_valid && head.is_mult;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_comb
    begin
        vr[0] = s1_reg.v0_re;
        vi[0] = s1_reg.v0_im;
        vr[1] = s1_reg.v1_re;
        vi[1] = s1_reg.v1_im;
        vr[2] = s1_reg.v2_re;
        vi[2] = s1_reg.v2_im;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic signed [VAL_W-1:0] mr, mi;
                mr = rdata[tensor_sel(r, c)][VAL_W-1:0];
                mi = rdata[tensor_sel(r, c)][ENTRY_W-1:VAL_W];
                prod_next[r][c][0] = mr * vr[c];
                prod_next[r][c][1] = mi * vi[c];
                prod_next[r][c][2] = mr * vi[c];
                prod_next[r][c][3] = mi * vr[c];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_re_next[r] = '0;
            acc_im_next[r] = '0;
            for (int c = 0; c < 3; c++)
            begin
                logic neg;
                logic signed [ACC_W-1:0] tre, tim;
                if (r == c) neg = 1'b0;
                else if (r + c == 1) neg = s2_nxy_reg;
                else if (r + c == 2) neg = s2_nxz_reg;
                else neg = s2_nyz_reg;
                tre = ACC_W'(prod_reg[r][c][0]) - ACC_W'(prod_reg[r][c][1]);
                tim = ACC_W'(prod_reg[r][c][2]) + ACC_W'(prod_reg[r][c][3]);
                acc_re_next[r] = neg ? (acc_re_next[r] - tre) : (acc_re_next[r] + tre);
                acc_im_next[r] = neg ? (acc_im_next[r] - tim) : (acc_im_next[r] + tim);
            end
        end
    end

    // round half up to q16.16, then clamp to 32 bits
    function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        begin
            t = (a + ACC_W'(32768)) >>> 16;
            if (t > ACC_W'(32'sh7fffffff)) return 32'sh7fffffff;
            else if (t < -ACC_W'(33'sh080000000)) return 32'sh80000000;
            else return t[VAL_W-1:0];
        end
    endfunction

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sat_re[r] = s3_bad_reg ? '0 : round_sat(acc_re_reg[r]);
            sat_im[r] = s3_bad_reg ? '0 : round_sat(acc_im_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= head;
        prod_reg    <= prod_next;
        s2_bad_reg  <= s1_reg.bad;
        s2_nxy_reg  <= s1_reg.neg_xy;
        s2_nxz_reg  <= s1_reg.neg_xz;
        s2_nyz_reg  <= s1_reg.neg_yz;
        acc_re_reg  <= acc_re_next;
        acc_im_reg  <= acc_im_next;
        s3_bad_reg  <= s2_bad_reg;
        result_reg.out0_re   <= sat_re[0];
        result_reg.out0_im   <= sat_im[0];
        result_reg.out1_re   <= sat_re[1];
        result_reg.out1_im   <= sat_im[1];
        result_reg.out2_re   <= sat_re[2];
        result_reg.out2_im   <= sat_im[2];
        result_reg.bad_index <= s3_bad_reg && s3_valid_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> src/fourier_tensor_vector_multiply.sv
// top level of the fourier-domain symmetric tensor-vector multiplier
// depends on ftvm_pkg, ftvm_front, ftvm_queue, ftvm_back
`timescale 1ns / 1ps

// One request per clock: a load writes one complex tensor entry and returns
// nothing; a multiply returns one result on the done strobe after start is taken,
// through the queue, store read, products, sums and rounding registers. The
// receiver cannot stall, so busy stays low in use and the rate is one request
// per cycle, set by the six 4096 x 64 single-port store rams, one per
// component, each serving one read or write a cycle. The store holds junk
// until loaded; an out-of-range index gives bad_index with zero results.
module fourier_tensor_vector_multiply
    import ftvm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output result_t              result
);

    entry_t front_entry, head;
    logic   head_valid, pop, full;

    ftvm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .entry     (front_entry)
    );

    ftvm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (start && !full),
        .push_data  (front_entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    ftvm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .done       (done),
        .result     (result)
    );

    assign busy = full;

endmodule

>>> src/ftvm_checker.sv
// port-level checker for the fourier tensor-vector multiplier, bound to the top
// depends on ftvm_pkg and fourier_tensor_vector_multiply_defines.svh
`timescale 1ns / 1ps
`include "fourier_tensor_vector_multiply_defines.svh"

module ftvm_checker
    import ftvm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input cmd_t                 cmd,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_data,
    input logic                 done,
    input result_t              result
);

    logic res_zero;

    assign res_zero = (result.out0_re == 0) && (result.out0_im == 0)
                      && (result.out1_re == 0) && (result.out1_im == 0)
                      && (result.out2_re == 0) && (result.out2_im == 0);

    // every result traces back to an earlier multiply request
    `FTVM_ASSERT_IMP(a_done_from_mult, done, $past(start && !busy && cmd.opcode == OP_MULT, 5))

    // a flagged index carries zero results
    `FTVM_ASSERT_IMP(a_bad_zero, done && result.bad_index, res_zero)

    // the flag shows only with a strobe
    `FTVM_ASSERT_IMP(a_bad_with_done, !done, !result.bad_index)

    // queue cannot fill while nothing arrives
    `FTVM_ASSERT_NEXT(a_idle_not_busy, !busy && !start, !busy)

endmodule

bind fourier_tensor_vector_multiply ftvm_checker u_checker (.*);

>>> tb/ftvm_checker.sv
// checker for the fourier tensor-vector multiplier: watches requests, register
// writes and results, predicts each multiply and compares it field by field
// depends on ftvm_pkg
`timescale 1ns / 1ps

module ftvm_scoreboard
    import ftvm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  cmd_t                 cmd,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 done,
    input  result_t              result,
    output int                   errors,
    output int                   pending
);

    localparam int TENSOR_IDX [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

    logic [ENTRY_W-1:0] tensor_mem [0:COMPONENTS*STORE_DEPTH-1];
    logic [CFG_W-1:0]   quad [3];
    logic [CFG_W-1:0]   padded [3];
    result_t            product_q [$];

    initial begin
        for (int i = 0; i < COMPONENTS * STORE_DEPTH; i++)
            tensor_mem[i] = '0;
    end

    // fold one padded index into the stored quadrant
    function automatic bit fold_axis(input logic [POS_W-1:0] pos, input logic [CFG_W-1:0] q,
                                     input logic [CFG_W-1:0] pad, output int idx,
                                     output bit neg);
        idx = 0;
        neg = 0;
        if (pos >= pad)
            return 0;
        if (pos >= q)
        begin
            idx = int'(pad) - int'(pos);
            neg = 1;
        end
        else
            idx = int'(pos);
        return idx < AXIS_MAX;
    endfunction

    function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [127:0] acc);
        logic signed [127:0] t;
        t = (acc + 128'sd32768) >>> 16;
        if (t > 128'sd2147483647)
            return 32'sh7fffffff;
        if (t < -128'sd2147483648)
            return 32'sh80000000;
        return t[VAL_W-1:0];
    endfunction

    function automatic result_t tensor_product(input cmd_t c);
        result_t             r;
        int                  idx [3];
        bit                  neg [3];
        bit                  ok;
        int                  base;
        logic [ENTRY_W-1:0]  m;
        logic signed [63:0]  mr, mi, vr, vi;
        logic signed [127:0] acc_re, acc_im, pre, pim;
        logic signed [VAL_W-1:0] vec [6];
        logic signed [VAL_W-1:0] outs [6];
        r = '0;
        ok = fold_axis(c.pos_x, quad[0], padded[0], idx[0], neg[0]);
        ok = ok && fold_axis(c.pos_y, quad[1], padded[1], idx[1], neg[1]);
        ok = ok && fold_axis(c.pos_z, quad[2], padded[2], idx[2], neg[2]);
        if (!ok)
        begin
            r.bad_index = 1'b1;
            return r;
        end
        base = (idx[2] * AXIS_MAX + idx[1]) * AXIS_MAX + idx[0];
        vec = '{c.val0_re, c.val0_im, c.val1_re, c.val1_im, c.val2_re, c.val2_im};
        for (int row = 0; row < 3; row++)
        begin
            acc_re = '0;
            acc_im = '0;
            for (int col = 0; col < 3; col++)
            begin
                m  = tensor_mem[TENSOR_IDX[row][col] * STORE_DEPTH + base];
                mr = $signed(m[31:0]);
                mi = $signed(m[63:32]);
                vr = vec[2*col];
                vi = vec[2*col+1];
                pre = 128'(mr * vr) - 128'(mi * vi);
                pim = 128'(mr * vi) + 128'(mi * vr);
                // off-diagonal terms take the product of the fold signs
                if (row != col && (neg[row] ^ neg[col]))
                begin
                    pre = -pre;
                    pim = -pim;
                end
                acc_re += pre;
                acc_im += pim;
            end
            outs[2*row]   = round_sat(acc_re);
            outs[2*row+1] = round_sat(acc_im);
        end
        r.out0_re = outs[0];
        r.out0_im = outs[1];
        r.out1_re = outs[2];
        r.out1_im = outs[3];
        r.out2_re = outs[4];
        r.out2_im = outs[5];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        int      addr;
        if (!rst_n)
        begin
            quad    = '{QUAD_RESET, QUAD_RESET, QUAD_RESET};
            padded  = '{PADDED_RESET, PADDED_RESET, PADDED_RESET};
            errors  = 0;
            pending = 0;
            product_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (product_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: result with no request outstanding: %h", $realtime, result);
                end
                else
                begin
                    want = product_q.pop_front();
                    if (want !== result)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%t: result mismatch", $realtime);
                            $display("  expected %h %h %h %h %h %h bad %b",
                                     want.out0_re, want.out0_im, want.out1_re,
                                     want.out1_im, want.out2_re, want.out2_im,
                                     want.bad_index);
                            $display("  actual   %h %h %h %h %h %h bad %b",
                                     result.out0_re, result.out0_im, result.out1_re,
                                     result.out1_im, result.out2_re, result.out2_im,
                                     result.bad_index);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                if (cmd.opcode == OP_MULT)
                    product_q.push_back(tensor_product(cmd));
                else if (cmd.component < COMPONENTS)
                begin
                    addr = ((int'(cmd.component) * AXIS_MAX + cmd.pos_z) * AXIS_MAX
                            + cmd.pos_y) * AXIS_MAX + cmd.pos_x;
                    tensor_mem[addr] = {cmd.val0_im, cmd.val0_re};
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_QUAD_X:   quad[0] = cfg_data;
                    CFG_QUAD_Y:   quad[1] = cfg_data;
                    CFG_QUAD_Z:   quad[2] = cfg_data;
                    CFG_PADDED_X: padded[0] = cfg_data;
                    CFG_PADDED_Y: padded[1] = cfg_data;
                    CFG_PADDED_Z: padded[2] = cfg_data;
                    default: ;
                endcase
            end
            pending = product_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// testbench top for the fourier tensor-vector multiplier: clock, reset,
// request and register stimulus, verdict; depends on ftvm_pkg, ftvm_scoreboard
`timescale 1ns / 1ps

module tb_top;
    import ftvm_pkg::*;

    // store positions filled for every component; multiplies only fold onto these
    localparam int FILL_POS [4] = '{0, 1, 7, 8};

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 cmd;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 done;
    result_t              result;
    int                   errors;
    int                   pending;
    bit                   no_gaps;
    int                   cur_quad [3];
    int                   cur_pad [3];

    fourier_tensor_vector_multiply dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    ftvm_scoreboard u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic signed [VAL_W-1:0] rand_value();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel < 4)
            return $urandom();
        if (sel < 12)
            return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
        if (sel == 12)
            return 32'sh7fffffff;
        if (sel == 13)
            return 32'sh80000000;
        if (sel == 14)
            return 32'sh00010000;
        return 32'shffff0000;
    endfunction

    function automatic cmd_t make_cmd(input opcode_t op, input int comp,
                                      input int x, input int y, input int z);
        cmd_t c;
        c.opcode    = op;
        c.component = comp[COMP_W-1:0];
        c.pos_x     = x[POS_W-1:0];
        c.pos_y     = y[POS_W-1:0];
        c.pos_z     = z[POS_W-1:0];
        c.val0_re   = rand_value();
        c.val0_im   = rand_value();
        c.val1_re   = rand_value();
        c.val1_im   = rand_value();
        c.val2_re   = rand_value();
        c.val2_im   = rand_value();
        return c;
    endfunction

    function automatic bit in_fill(input int v);
        bit hit;
        hit = 0;
        for (int i = 0; i < 4; i++)
            if (FILL_POS[i] == v)
                hit = 1;
        return hit;
    endfunction

    // padded index for one axis that is either flagged or folds onto a filled position
    function automatic int pick_pos(input int axis);
        int cands [$];
        int idx;
        for (int p = 0; p < AXIS_MAX; p++)
        begin
            if (p >= cur_pad[axis])
                cands.push_back(p);
            else
            begin
                idx = (p >= cur_quad[axis]) ? cur_pad[axis] - p : p;
                if (idx >= AXIS_MAX || in_fill(idx))
                    cands.push_back(p);
            end
        end
        if (cands.size() == 0)
            return 0;
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    task automatic issue(input cmd_t c);
        int gap;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        if (no_gaps)
            gap = 0;
        else if ($urandom_range(0, 19) == 0)
            gap = $urandom_range(10, 40);
        else if ($urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 3);
        else
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_axes(input int qx, input int qy, input int qz,
                            input int px, input int py, input int pz);
        cur_quad = '{qx, qy, qz};
        cur_pad  = '{px, py, pz};
        write_reg(CFG_QUAD_X, qx);
        write_reg(CFG_QUAD_Y, qy);
        write_reg(CFG_QUAD_Z, qz);
        write_reg(CFG_PADDED_X, px);
        write_reg(CFG_PADDED_Y, py);
        write_reg(CFG_PADDED_Z, pz);
    endtask

    // mostly multiplies, with loads (some to non-existent components) mixed in
    task automatic random_phase(input int count);
        cmd_t c;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 4) == 0)
                c = make_cmd(OP_LOAD, $urandom_range(0, 7), $urandom_range(0, 15),
                             $urandom_range(0, 15), $urandom_range(0, 15));
            else
                c = make_cmd(OP_MULT, $urandom_range(0, 7), pick_pos(0),
                             pick_pos(1), pick_pos(2));
            issue(c);
        end
        no_gaps = 0;
        drain();
    endtask

    initial
    begin
        cmd_t c;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        no_gaps   = 1;
        cur_quad  = '{int'(QUAD_RESET), int'(QUAD_RESET), int'(QUAD_RESET)};
        cur_pad   = '{int'(PADDED_RESET), int'(PADDED_RESET), int'(PADDED_RESET)};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every component at the positions that multiplies are steered to
        for (int comp = 0; comp < COMPONENTS; comp++)
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    for (int k = 0; k < 4; k++)
                        issue(make_cmd(OP_LOAD, comp, FILL_POS[i], FILL_POS[j],
                                       FILL_POS[k]));
        no_gaps = 0;

        // extreme entries at the origin
        for (int comp = 0; comp < COMPONENTS; comp++)
        begin
            c = make_cmd(OP_LOAD, comp, 0, 0, 0);
            c.val0_re = comp[0] ? 32'sh80000000 : 32'sh7fffffff;
            c.val0_im = comp[0] ? 32'sh7fffffff : 32'sh80000000;
            issue(c);
        end
        // loads to components past the last are dropped
        issue(make_cmd(OP_LOAD, 6, 0, 0, 0));
        issue(make_cmd(OP_LOAD, 7, 15, 15, 15));
        c = make_cmd(OP_MULT, 0, 0, 0, 0);
        {c.val0_re, c.val0_im, c.val1_re} = {3{32'sh7fffffff}};
        {c.val1_im, c.val2_re, c.val2_im} = {3{32'sh7fffffff}};
        issue(c);
        c = make_cmd(OP_MULT, 0, 0, 0, 0);
        {c.val0_re, c.val0_im, c.val1_re} = {3{32'sh80000000}};
        {c.val1_im, c.val2_re, c.val2_im} = {3{32'sh80000000}};
        issue(c);
        c = make_cmd(OP_MULT, 0, 0, 0, 0);
        {c.val0_re, c.val0_im, c.val1_re, c.val1_im, c.val2_re, c.val2_im} = '0;
        issue(c);
        // fold threshold at the quadrant size, mixed signs across axes
        issue(make_cmd(OP_MULT, 0, 8, 8, 8));
        issue(make_cmd(OP_MULT, 0, 9, 9, 9));
        issue(make_cmd(OP_MULT, 0, 9, 0, 15));
        issue(make_cmd(OP_MULT, 0, 15, 15, 15));
        issue(make_cmd(OP_MULT, 0, 0, 9, 15));
        drain();

        // largest quadrant: no folding at all
        set_axes(16, 16, 16, 16, 16, 16);
        random_phase(100);
        // smallest legal sizes, plenty of out-of-range indices
        set_axes(1, 1, 1, 2, 2, 2);
        issue(make_cmd(OP_MULT, 0, 1, 1, 1));
        issue(make_cmd(OP_MULT, 0, 2, 0, 0));
        random_phase(100);
        // out-of-range register values, and writes past the register list
        write_reg(3'd6, 31);
        write_reg(3'd7, 0);
        set_axes(0, 31, 16, 31, 31, 1);
        random_phase(100);
        for (int p = 0; p < 4; p++)
        begin
            set_axes($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
            random_phase(80);
        end
        set_axes(9, 5, 13, 16, 10, 16);
        random_phase(60);
        set_axes(QUAD_RESET, QUAD_RESET, QUAD_RESET, PADDED_RESET, PADDED_RESET, PADDED_RESET);
        random_phase(60);

        if (errors == 0)
            $display("** fourier_tensor_vector_multiply: PASSED **");
        else
            $display("** fourier_tensor_vector_multiply: FAILED **");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("** fourier_tensor_vector_multiply: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/ftvm_pkg.sv
src/ftvm_ram.sv
src/ftvm_front.sv
src/ftvm_queue.sv
src/ftvm_back.sv
src/fourier_tensor_vector_multiply.sv
src/ftvm_checker.sv
tb/ftvm_checker.sv
tb/tb_top.sv
